/* src/atpi_pkg.sv */
package atpi_pkg;

    // field widths of the stream payloads
    localparam int ADDR_W      = 64;
    localparam int BYTES_W     = 32;
    localparam int TOTAL_W     = 64;
    localparam int SLOT_USED_W = 10;
    localparam int STATUS_W    = 2;

    // packed stream widths, tdata padded to whole bytes
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    // default table depth
    localparam int TABLE_SLOTS_DEF = 1024;

    // start slot arithmetic: the shifted address lies in (-2^28, 2^28)
    localparam int HASH_SPAN_W = 28;
    localparam int HASH_U_W    = HASH_SPAN_W + 2;
    localparam int HASH_LOW_W  = 32;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_STORED  = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_IGNORED = 2'd2
    } status_t;

    // one table slot
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [BYTES_W-1:0] bytes;
        logic               array_form;
        logic               freed;
    } slot_entry_t;

endpackage

/* src/atpi_slot_hash.sv */
module atpi_slot_hash #(
    parameter int TABLE_SLOTS = atpi_pkg::TABLE_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [atpi_pkg::HASH_LOW_W-1:0]   addr_low,
    output logic                              done,
    output logic [$clog2(TABLE_SLOTS)-1:0]    slot
);
    import atpi_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int U_W    = HASH_U_W;
    localparam int R_W    = U_W + 1;
    localparam int SHIFT  = U_W + SLOT_W;
    localparam int PROD_W = U_W + R_W;
    localparam int Q_W    = PROD_W - SHIFT;
    localparam int QN_W   = Q_W + SLOT_W + 1;
    localparam longint unsigned RECIP  = (64'd1 << SHIFT) / TABLE_SLOTS;
    localparam longint unsigned OFFSET =
        (((64'd1 << HASH_SPAN_W) + TABLE_SLOTS - 1) / TABLE_SLOTS) * TABLE_SLOTS;

    localparam logic [R_W-1:0]    RECIP_C = R_W'(RECIP);
    localparam logic [SLOT_W:0]   SLOTS_C = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [U_W-1:0]    SLOTS_U = U_W'(TABLE_SLOTS);

    logic [HASH_LOW_W-1:0] shr_q;
    logic [HASH_LOW_W-1:0] biased;
    logic [Q_W-1:0]        quot;
    logic [QN_W-1:0]       quot_n;
    logic [U_W-1:0]        rem_est;
    logic [U_W-1:0]        rem_fix;

    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  done_reg;
    logic [U_W-1:0]        u1_reg;
    logic [U_W-1:0]        u2_reg;
    logic [U_W-1:0]        u3_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [U_W-1:0]        qn_reg;
    logic [SLOT_W-1:0]     slot_reg;

    // arithmetic shift by 3 with the extra +1 for negative values, then bias to non-negative
    assign shr_q  = {{3{addr_low[HASH_LOW_W-1]}}, addr_low[HASH_LOW_W-1:3]}
                    + {{(HASH_LOW_W-1){1'b0}}, addr_low[HASH_LOW_W-1]};
    assign biased = shr_q + HASH_LOW_W'(OFFSET);

    // quotient estimate from the reciprocal, low by at most one
    assign quot   = prod_reg[PROD_W-1:SHIFT];
    assign quot_n = quot * SLOTS_C;

    // remainder with a single correction step
    assign rem_est = u3_reg - qn_reg;
    assign rem_fix = (rem_est >= SLOTS_U) ? (rem_est - SLOTS_U) : rem_est;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // datapath stages: bias, multiply, back-multiply, correct
    always_ff @(posedge clk)
    begin
        u1_reg   <= biased[U_W-1:0];
        prod_reg <= u1_reg * RECIP_C;
        u2_reg   <= u1_reg;
        qn_reg   <= quot_n[U_W-1:0];
        u3_reg   <= u2_reg;
        slot_reg <= rem_fix[SLOT_W-1:0];
    end

    assign done = done_reg;
    assign slot = slot_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done)
        else $error("start slot not ready four cycles after start");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (slot <= SLOT_W'(TABLE_SLOTS - 1)))
        else $error("start slot outside the table");

endmodule

/* src/allocation_tracker_probe_insert_unit.sv */
// channel   | direction | signals                         | contents (lowest bit first)
// s_axis    | in        | tvalid tready tdata[95:0] tuser | tdata: alloc_address, alloc_bytes;
//           |           |                                 | tuser: array_form
// m_axis    | out       | tvalid tready tdata[79:0] tuser | tdata: slot_used, running_total, pad;
//           |           |                                 | tuser: insert_status
// cfg       | in        | valid ready data[0]             | recording_enabled
//
// one item at a time: accept, start slot arithmetic, each probe through the slot memory
// read port, then hand the result to the output register; an ignored item skips the
// arithmetic and the probes
// after reset a clearing pass writes every slot empty, with s_axis_tready low
// the result waits in the output register; the next item can be taken while it is held
module allocation_tracker_probe_insert_unit #(
    parameter int TABLE_SLOTS = atpi_pkg::TABLE_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [atpi_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // alloc_address, alloc_bytes
    input  logic [atpi_pkg::S_TUSER_W-1:0]    s_axis_tuser,   // array_form

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [atpi_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // slot_used, running_total, pad
    output logic [atpi_pkg::M_TUSER_W-1:0]    m_axis_tuser,   // insert_status

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data        // recording_enabled
);
    import atpi_pkg::*;

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int PAD_W   = M_TDATA_W - TOTAL_W - SLOT_USED_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_RESULT
    } state_t;

    state_t                 state_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]      probe_cnt_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [BYTES_W-1:0]     bytes_reg;
    logic                   arr_reg;
    logic [TOTAL_W-1:0]     total_reg;
    status_t                res_status_reg;
    logic [SLOT_W-1:0]      res_slot_reg;
    logic                   m_valid_reg;
    status_t                out_status_reg;
    logic [SLOT_USED_W-1:0] out_slot_used_reg;
    logic [TOTAL_W-1:0]     out_total_reg;
    logic                   recording_enabled_reg;

    slot_entry_t            slot_mem [TABLE_SLOTS];
    slot_entry_t            rd_data_reg;
    logic [SLOT_W-1:0]      rd_addr_q_reg;

    logic                   s_accept;
    logic                   hash_start;
    logic                   hash_done;
    logic [SLOT_W-1:0]      hash_slot;
    logic                   hit;
    logic                   store;
    logic [SLOT_W-1:0]      next_slot;
    logic                   rd_en;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    slot_entry_t            wr_data;
    logic                   out_free;
    logic [SLOT_W+SLOT_USED_W-1:0] slot_ext;

    // start slot unit
    atpi_slot_hash #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (hash_start),
        .addr_low (s_axis_tdata[HASH_LOW_W-1:0]),
        .done     (hash_done),
        .slot     (hash_slot)
    );

    // handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign hash_start    = s_accept && recording_enabled_reg;
    assign cfg_ready     = 1'b1;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // probe decision on the slot just read
    assign hit       = (rd_data_reg.address == '0) || (rd_data_reg.address == addr_reg);
    assign store     = (state_reg == ST_PROBE) && hit;
    assign next_slot = (slot_reg == LAST_SLOT) ? '0 : (slot_reg + 1'b1);

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = next_slot;
        wr_en   = 1'b0;
        wr_addr = slot_reg;
        wr_data = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_HASH:
            begin
                rd_en   = hash_done;
                rd_addr = hash_slot;
            end
            ST_PROBE:
            begin
                rd_en              = !hit;
                wr_en              = hit;
                wr_data.address    = addr_reg;
                wr_data.bytes      = bytes_reg;
                wr_data.array_form = arr_reg;
                wr_data.freed      = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg   <= slot_mem[rd_addr];
            rd_addr_q_reg <= rd_addr;
        end
    end

    // recording enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recording_enabled_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            recording_enabled_reg <= cfg_data;
        end
    end

    assign slot_ext = {{SLOT_USED_W{1'b0}}, res_slot_reg};

    // control sequence and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            slot_reg          <= '0;
            probe_cnt_reg     <= '0;
            addr_reg          <= '0;
            bytes_reg         <= '0;
            arr_reg           <= 1'b0;
            total_reg         <= '0;
            res_status_reg    <= STATUS_STORED;
            res_slot_reg      <= '0;
            m_valid_reg       <= 1'b0;
            out_status_reg    <= STATUS_STORED;
            out_slot_used_reg <= '0;
            out_total_reg     <= '0;
        end
        else
        begin
            // a result in ST_RESULT reloads the output register instead
            if (m_valid_reg && m_axis_tready && (state_reg != ST_RESULT))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    slot_reg <= next_slot;
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        addr_reg  <= s_axis_tdata[ADDR_W-1:0];
                        bytes_reg <= s_axis_tdata[ADDR_W+BYTES_W-1:ADDR_W];
                        arr_reg   <= s_axis_tuser[0];
                        if (recording_enabled_reg)
                        begin
                            state_reg <= ST_HASH;
                        end
                        else
                        begin
                            res_status_reg <= STATUS_IGNORED;
                            res_slot_reg   <= '0;
                            state_reg      <= ST_RESULT;
                        end
                    end
                end
                ST_HASH:
                begin
                    if (hash_done)
                    begin
                        slot_reg      <= hash_slot;
                        probe_cnt_reg <= '0;
                        state_reg     <= ST_PROBE;
                    end
                end
                ST_PROBE:
                begin
                    priority if (hit)
                    begin
                        total_reg      <= total_reg + TOTAL_W'(bytes_reg);
                        res_status_reg <= STATUS_STORED;
                        res_slot_reg   <= slot_reg;
                        state_reg      <= ST_RESULT;
                    end
                    else if (probe_cnt_reg == LAST_SLOT)
                    begin
                        res_status_reg <= STATUS_FULL;
                        res_slot_reg   <= '0;
                        state_reg      <= ST_RESULT;
                    end
                    else
                    begin
                        slot_reg      <= next_slot;
                        probe_cnt_reg <= probe_cnt_reg + 1'b1;
                    end
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg       <= 1'b1;
                        out_status_reg    <= res_status_reg;
                        out_slot_used_reg <= slot_ext[SLOT_USED_W-1:0];
                        out_total_reg     <= total_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // output packing
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_total_reg, out_slot_used_reg};
    assign m_axis_tuser  = out_status_reg;

    a_total_add: assert property (@(posedge clk) disable iff (!rst_n)
        store |=> (total_reg == ($past(total_reg) + TOTAL_W'($past(bytes_reg)))))
        else $error("running total not advanced by the stored byte count");

    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !store |=> $stable(total_reg))
        else $error("running total changed without a store");

    a_probe_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (rd_addr_q_reg == slot_reg))
        else $error("slot read data does not belong to the probed slot");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_axis_tready)
        else $error("second item taken while one is in progress");

endmodule

/* tb/allocation_tracker_probe_insert_checker.sv */
module allocation_tracker_probe_insert_checker #(
    parameter int TABLE_SLOTS = atpi_pkg::TABLE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [atpi_pkg::S_TDATA_W-1:0] s_axis_tdata,    // alloc_address, alloc_bytes
    input  logic [atpi_pkg::S_TUSER_W-1:0] s_axis_tuser,    // array_form

    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [atpi_pkg::M_TDATA_W-1:0] m_axis_tdata,    // slot_used, running_total, pad
    input  logic [atpi_pkg::M_TUSER_W-1:0] m_axis_tuser,    // insert_status

    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic                           cfg_data,

    output int                             mismatch_count,
    output int                             results_pending,
    output int                             stored_count,
    output int                             full_count,
    output int                             ignored_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import atpi_pkg::*;

    typedef struct packed {
        status_t                  status;
        logic [SLOT_USED_W-1:0]   slot;
        logic [TOTAL_W-1:0]       total;
    } insert_result_t;

    // shadow of the slot table: only the owner address decides the probe
    logic [ADDR_W-1:0]  slot_owner [TABLE_SLOTS];
    logic [TOTAL_W-1:0] bytes_recorded;
    logic               recording_on;
    insert_result_t     expected_results [$];

    int failures;
    int n_stored;
    int n_full;
    int n_ignored;

    // home slot: signed low word, arithmetic shift by 3, +1 when negative, non-negative modulo
    function automatic int home_slot(input logic [ADDR_W-1:0] addr);
        logic signed [31:0] low;
        int                 shifted;
        int                 r;
        low = addr[31:0];
        shifted = low >>> 3;
        if (low[31])
        begin
            shifted = shifted + 1;
        end
        r = shifted % TABLE_SLOTS;
        if (r < 0)
        begin
            r = r + TABLE_SLOTS;
        end
        return r;
    endfunction

    // linear probe from the home slot, wrapping, until empty or same owner
    function automatic insert_result_t probe_and_insert(input logic [ADDR_W-1:0] addr,
                                                        input logic [BYTES_W-1:0] nbytes);
        insert_result_t res;
        int             slot;
        int             n;
        res.status = STATUS_FULL;
        res.slot   = '0;
        res.total  = bytes_recorded;
        if (!recording_on)
        begin
            res.status = STATUS_IGNORED;
            return res;
        end
        slot = home_slot(addr);
        for (n = 0; n < TABLE_SLOTS; n++)
        begin
            if (slot_owner[slot] == '0 || slot_owner[slot] == addr)
            begin
                slot_owner[slot] = addr;
                bytes_recorded   = bytes_recorded + TOTAL_W'(nbytes);
                res.status = STATUS_STORED;
                res.slot   = SLOT_USED_W'(slot);
                res.total  = bytes_recorded;
                return res;
            end
            slot = (slot + 1 == TABLE_SLOTS) ? 0 : slot + 1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        insert_result_t want;
        insert_result_t got;
        if (!rst_n)
        begin
            foreach (slot_owner[i])
            begin
                slot_owner[i] = '0;
            end
            bytes_recorded = '0;
            recording_on   = 1'b0;
            expected_results.delete();
            failures  = 0;
            n_stored  = 0;
            n_full    = 0;
            n_ignored = 0;
        end
        else
        begin
            // result transaction against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = status_t'(m_axis_tuser);
                got.slot   = m_axis_tdata[SLOT_USED_W-1:0];
                got.total  = m_axis_tdata[SLOT_USED_W +: TOTAL_W];
                if (expected_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("%t: result with none expected: status %0d slot %0d total %0h",
                                 $realtime, got.status, got.slot, got.total);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    case (want.status)
                        STATUS_STORED: n_stored++;
                        STATUS_FULL:   n_full++;
                        default:       n_ignored++;
                    endcase
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.total !== want.total)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("%t: mismatch: status %0d/%0d slot %0d/%0d total %0h/%0h",
                                     $realtime, want.status, got.status, want.slot, got.slot,
                                     want.total, got.total);
                            $display("    (expected/actual)");
                        end
                    end
                end
            end

            // input transaction: predict its result with the register value before this edge
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(probe_and_insert(s_axis_tdata[ADDR_W-1:0],
                                                            s_axis_tdata[ADDR_W +: BYTES_W]));
            end

            // register write
            if (cfg_valid && cfg_ready)
            begin
                recording_on = cfg_data;
            end
        end
        mismatch_count  <= failures;
        results_pending <= expected_results.size();
        stored_count    <= n_stored;
        full_count      <= n_full;
        ignored_count   <= n_ignored;
    end

endmodule

/* tb/allocation_tracker_probe_insert_unit_tb.sv */
module allocation_tracker_probe_insert_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import atpi_pkg::*;

    localparam int SLOTS        = TABLE_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 300;

    logic                 clk;
    logic                 rst_n         = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;    // alloc_address, alloc_bytes
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;    // array_form

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;          // slot_used, running_total, pad
    logic [M_TUSER_W-1:0] m_axis_tuser;          // insert_status

    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data      = 1'b0;

    int mismatch_count;
    int results_pending;
    int stored_count;
    int full_count;
    int ignored_count;

    // stimulus knobs
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_req_cnt  = 0;
    int items_sent    = 0;
    int hot_slot [8];

    // addresses that occupy a slot, as far as the stimulus knows
    bit                recording_now;
    bit                addr_known [logic [ADDR_W-1:0]];
    logic [ADDR_W-1:0] known_list [$];

    allocation_tracker_probe_insert_unit #(
        .TABLE_SLOTS (SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    allocation_tracker_probe_insert_checker #(
        .TABLE_SLOTS (SLOTS)
    ) alloc_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .stored_count    (stored_count),
        .full_count      (full_count),
        .ignored_count   (ignored_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(100_000_000);
        $display("Verification failed");
        $finish;
    end

    // result side: random back-pressure, plus long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        int hold_left;
        int hold_served;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left   = 0;
            hold_served = 0;
        end
        else if (hold_served != hold_req_cnt)
        begin
            hold_served   = hold_req_cnt;
            hold_left     = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // one allocation transaction, then an optional idle gap
    task automatic send_alloc(input logic [ADDR_W-1:0] addr, input logic [BYTES_W-1:0] nbytes,
                              input logic arr);
        s_axis_tdata  <= {nbytes, addr};
        s_axis_tuser  <= arr;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        if (recording_now && addr != '0 && !addr_known.exists(addr) && known_list.size() < SLOTS)
        begin
            addr_known[addr] = 1'b1;
            known_list.push_back(addr);
        end
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // stop offering and wait for every predicted result
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_recording(input logic on);
        wait_results_done();
        cfg_data  <= on;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        recording_now = on;
    endtask

    // mix of repeats, zero, clustered, negative and fully random addresses
    task automatic send_random_alloc();
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] nbytes;
        int                 sel;
        sel = $urandom_range(99);
        if (sel < 22 && known_list.size() > 0)
        begin
            addr = known_list[$urandom_range(known_list.size() - 1)];
        end
        else if (sel < 27)
        begin
            addr = '0;
        end
        else if (sel < 57)
        begin
            addr = {$urandom(), 32'((hot_slot[$urandom_range(7)] << 3) + $urandom_range(23))};
        end
        else if (sel < 67)
        begin
            addr = {$urandom(), 1'b1, 31'($urandom())};
        end
        else
        begin
            addr = {$urandom(), $urandom()};
        end
        case ($urandom_range(9))
            0:       nbytes = '0;
            1:       nbytes = '1;
            default: nbytes = $urandom();
        endcase
        send_alloc(addr, nbytes, 1'($urandom_range(1)));
    endtask

    // stimulus
    initial
    begin
        logic [ADDR_W-1:0] addr;
        int                k;
        recording_now = 1'b0;
        foreach (hot_slot[i])
        begin
            hot_slot[i] = $urandom_range(SLOTS - 1);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // recording off out of reset, then with an explicit write of zero
        send_alloc('1, '1, 1'b1);
        write_recording(1'b0);
        send_alloc(64'h0000_0000_8000_0000, 32'h0000_0001, 1'b0);
        write_recording(1'b1);

        // zero address, sign extremes of the low word, wraparound, repeats, probe chains
        send_alloc('0, '1, 1'b0);
        send_alloc('0, 32'd5, 1'b1);
        send_alloc('1, '1, 1'b1);
        send_alloc(64'h0000_0000_8000_0000, 32'd1, 1'b0);
        send_alloc(64'h0000_0000_7FFF_FFF8, '0, 1'b0);
        send_alloc(64'hFFFF_FFFF_7FFF_FFFF, 32'd3, 1'b1);
        send_alloc(64'h0000_0000_7FFF_FFF8, 32'd77, 1'b1);
        send_alloc(64'h0000_0001_0000_0100, 32'h8000_0000, 1'b0);
        send_alloc(64'h0000_0002_0000_0107, 32'h7FFF_FFFF, 1'b1);
        send_alloc(64'h0000_0003_0000_0108, 32'd9, 1'b0);
        send_alloc(64'h0000_0004_0000_00F8, 32'd11, 1'b1);
        send_alloc(64'h0000_0002_0000_0107, 32'd13, 1'b0);
        send_alloc(64'hFFFF_FFFF_0000_0000, 32'd17, 1'b1);
        send_alloc(64'h8000_0000_0000_0008, 32'd19, 1'b0);
        send_alloc(64'h0000_0000_FFFF_FFF8, 32'd23, 1'b1);
        send_alloc(64'hAAAA_AAAA_5555_5555, 32'hA5A5_A5A5, 1'b0);
        send_alloc(64'h5555_5555_AAAA_AAAA, 32'h5A5A_5A5A, 1'b1);

        // sender idles lightly, receiver heavily
        tx_idle_pct = 28;
        rx_idle_pct = 46;
        repeat (RANDOM_ITEMS * 2 / 5) send_random_alloc();
        write_recording(1'b0);
        repeat (RANDOM_ITEMS / 10) send_random_alloc();
        write_recording(1'b1);

        // roles swapped, with one long output hold-off while items keep coming
        tx_idle_pct = 46;
        rx_idle_pct = 28;
        repeat (RANDOM_ITEMS / 5) send_random_alloc();
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (RANDOM_ITEMS / 5) send_random_alloc();
        wait_results_done();

        // no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (RANDOM_ITEMS / 10) send_random_alloc();

        // fill every slot with fresh addresses spread over the table
        k = 0;
        while (known_list.size() < SLOTS)
        begin
            addr = {$urandom() | 32'h1, 32'(k << 3)};
            if (!addr_known.exists(addr))
            begin
                send_alloc(addr, $urandom(), 1'($urandom_range(1)));
            end
            k = (k + 1) % SLOTS;
        end

        // full table: new addresses and zero are dropped, known ones still match
        repeat (4) send_alloc({$urandom() | 32'h1, $urandom()}, $urandom(), 1'b1);
        send_alloc('0, 32'd1, 1'b0);
        repeat (3) send_alloc(known_list[$urandom_range(SLOTS - 1)], $urandom(), 1'b0);
        write_recording(1'b0);
        send_alloc({$urandom(), $urandom()}, $urandom(), 1'b1);

        // drain, then leave room for any stray result
        wait_results_done();
        repeat (SLOTS + 16) @(posedge clk);

        $display("%0d allocation transactions: %0d stored, %0d dropped on a full table, %0d ignored",
                 items_sent, stored_count, full_count, ignored_count);
        $display("covered edge addresses, probe chains with wraparound, repeats, a long stall");
        if (mismatch_count == 0 && results_pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
